>>> sv/biquad_adc_to_dac_filter_assert.svh
// assertion helpers for the biquad filter
`ifndef BIQUAD_ADC_TO_DAC_FILTER_ASSERT_SVH
`define BIQUAD_ADC_TO_DAC_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bq_pkg.sv
package bq_pkg;

   localparam int PC_W    = 4;
   localparam int X_W     = 16;
   localparam int Y_W     = 40;
   localparam int COEF_W  = 32;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = COEF_W + MUL_B_W;
   localparam int ACC_W   = 74;
   localparam int N_W     = 51;
   localparam int M_W     = N_W - 16;
   localparam int P_W     = 25;
   localparam int CODE_W  = 12;
   localparam int ADDR_W  = 5;
   localparam int IDX_W   = 3;

   // dac scaling 8190/65535 reduces to 546/(4369*65536)
   localparam int DAC_DIV  = 4369;
   localparam int DAC_HALF = 143163392;   // 4369 * 32768
   localparam int DAC_OFS  = 8947712;     // 2048 * 4369
   localparam int DAC_MAX  = 4095;

   // register indexes
   localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
   localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

   // program addresses
   localparam logic [PC_W-1:0] S_WAIT   = 4'd0;
   localparam logic [PC_W-1:0] S_MB0    = 4'd1;
   localparam logic [PC_W-1:0] S_MB1    = 4'd2;
   localparam logic [PC_W-1:0] S_MB2    = 4'd3;
   localparam logic [PC_W-1:0] S_MA1H   = 4'd4;
   localparam logic [PC_W-1:0] S_MA1L   = 4'd5;
   localparam logic [PC_W-1:0] S_MA2H   = 4'd6;
   localparam logic [PC_W-1:0] S_MA2L   = 4'd7;
   localparam logic [PC_W-1:0] S_LAST   = 4'd8;
   localparam logic [PC_W-1:0] S_SAT    = 4'd9;
   localparam logic [PC_W-1:0] S_DAC_M  = 4'd10;
   localparam logic [PC_W-1:0] S_DAC_Q  = 4'd11;
   localparam logic [PC_W-1:0] S_EMIT   = 4'd12;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_B0_X, MUL_B1_X1, MUL_B2_X2,
      MUL_A1_Y1H, MUL_A1_Y1L, MUL_A2_Y2H, MUL_A2_Y2L
   } bq_mul_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} bq_acc_type;

   typedef enum logic [2:0] {DP_NONE, DP_SAT, DP_DAC_M, DP_DAC_Q, DP_DAC_CODE} bq_dp_type;

   typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_REQ, JMP_WAIT_OUT, JMP_GOTO} bq_jmp_type;

   typedef struct packed {
      bq_mul_type      mul_sel;
      bq_acc_type      acc_op;
      logic            acc_shift;
      bq_dp_type       dp_op;
      bq_jmp_type      jump;
      logic [PC_W-1:0] target;
   } bq_ctrl_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } bq_coef_set_type;

   // microcode rom, one control word per step
   function automatic bq_ctrl_type bq_ucode(input logic [PC_W-1:0] pc);
      bq_ctrl_type c;
      c = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, acc_shift: 1'b0,
            dp_op: DP_NONE, jump: JMP_NEXT, target: S_WAIT};
      case (pc)
         S_WAIT:  c.jump = JMP_WAIT_REQ;
         S_MB0:   c.mul_sel = MUL_B0_X;
         S_MB1: begin
            c.mul_sel = MUL_B1_X1; c.acc_op = ACC_LOAD; c.acc_shift = 1'b1;
         end
         S_MB2: begin
            c.mul_sel = MUL_B2_X2; c.acc_op = ACC_ADD; c.acc_shift = 1'b1;
         end
         S_MA1H: begin
            c.mul_sel = MUL_A1_Y1H; c.acc_op = ACC_ADD; c.acc_shift = 1'b1;
         end
         S_MA1L: begin
            c.mul_sel = MUL_A1_Y1L; c.acc_op = ACC_SUB; c.acc_shift = 1'b1;
         end
         S_MA2H: begin
            c.mul_sel = MUL_A2_Y2H; c.acc_op = ACC_SUB;
         end
         S_MA2L: begin
            c.mul_sel = MUL_A2_Y2L; c.acc_op = ACC_SUB; c.acc_shift = 1'b1;
         end
         S_LAST:  c.acc_op = ACC_SUB;
         S_SAT:   c.dp_op = DP_SAT;
         S_DAC_M: c.dp_op = DP_DAC_M;
         S_DAC_Q: c.dp_op = DP_DAC_Q;
         S_EMIT: begin
            c.dp_op = DP_DAC_CODE; c.jump = JMP_WAIT_OUT; c.target = S_WAIT;
         end
         default: begin
            c.jump = JMP_GOTO; c.target = S_WAIT;
         end
      endcase
      return c;
   endfunction

endpackage

>>> sv/biquad_adc_to_dac_filter.sv
// channel   dir  data                          side
// req       in   tdata[15:0] adc_sample        tuser[0] restart
// rsp       out  tdata[11:0] dac_code          -
// csr       in   apb, five coefficient regs    pready tied high
//
// a request runs through the program steps in order: the wait step, seven
// passes through one shared 32x25 multiplier, a last subtract, saturate and
// three dac scaling steps
// reset clears the program counter, the history and the coefficients
// a stalled result holds the last step; the next request is taken as soon as
// the result register is loaded, while that result waits on rsp_tready
module biquad_adc_to_dac_filter #(
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] adc_sample
   input  logic        req_tuser,   // [0] restart

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] dac_code, upper bits zero

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bq_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

`include "biquad_adc_to_dac_filter_assert.svh"

   bq_pkg::bq_ctrl_type             ctrl;
   bq_pkg::bq_coef_set_type         coefs_ff;
   logic [bq_pkg::IDX_W-1:0]        csr_idx;
   logic                            csr_wr;
   logic                            req_fire;
   logic                            out_busy;
   logic                            dac_load;
   logic [bq_pkg::CODE_W-1:0]       code;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [bq_pkg::CODE_W-1:0]       rsp_code_ff;

   // --- configuration port ---
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[bq_pkg::ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_idx)
         bq_pkg::REG_B0: csr_prdata = coefs_ff.b0;
         bq_pkg::REG_B1: csr_prdata = coefs_ff.b1;
         bq_pkg::REG_B2: csr_prdata = coefs_ff.b2;
         bq_pkg::REG_A1: csr_prdata = coefs_ff.a1;
         bq_pkg::REG_A2: csr_prdata = coefs_ff.a2;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            bq_pkg::REG_B0: coefs_ff.b0 <= csr_pwdata;
            bq_pkg::REG_B1: coefs_ff.b1 <= csr_pwdata;
            bq_pkg::REG_B2: coefs_ff.b2 <= csr_pwdata;
            bq_pkg::REG_A1: coefs_ff.a1 <= csr_pwdata;
            bq_pkg::REG_A2: coefs_ff.a2 <= csr_pwdata;
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   // --- handshakes ---
   // requests are only taken in the wait step of the program, never in reset
   assign req_tready = (ctrl.jump == bq_pkg::JMP_WAIT_REQ) & ~reset;
   assign req_fire   = req_tvalid & req_tready;

   // result slot is free when empty or draining this cycle
   assign out_busy = rsp_tvalid_ff & ~rsp_tready;
   assign dac_load = (ctrl.dp_op == bq_pkg::DP_DAC_CODE) & ~out_busy;

   bq_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_busy  (out_busy),
      .ctrl      (ctrl)
   );

   bq_datapath #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .coefs       (coefs_ff),
      .req_fire    (req_fire),
      .req_sample  (req_tdata),
      .req_restart (req_tuser),
      .code        (code)
   );

   // --- result register ---
   assign rsp_tvalid_in = dac_load | out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dac_load) begin
         rsp_code_ff <= code;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(16-bq_pkg::CODE_W){1'b0}}, rsp_code_ff};

   // --- checks ---
   `BQ_ASSERT_NEXT(a_start_mac, req_fire, ctrl.mul_sel == bq_pkg::MUL_B0_X, "no mac start")
   `BQ_ASSERT_NEXT(a_one_in_flight, req_fire, !req_tready, "request taken in flight")
   `BQ_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_tvalid_ff), $past(dac_load), "early result")

endmodule

>>> sv/bq_sequencer.sv
module bq_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                out_busy,
   output bq_pkg::bq_ctrl_type ctrl
);

   logic [bq_pkg::PC_W-1:0] pc_ff;
   logic [bq_pkg::PC_W-1:0] pc_in;

   assign ctrl = bq_pkg::bq_ucode(pc_ff);

   always_comb begin
      case (ctrl.jump)
         bq_pkg::JMP_NEXT:     pc_in = pc_ff + 1'b1;
         bq_pkg::JMP_WAIT_REQ: pc_in = req_valid ? pc_ff + 1'b1 : pc_ff;
         bq_pkg::JMP_WAIT_OUT: pc_in = out_busy ? pc_ff : ctrl.target;
         bq_pkg::JMP_GOTO:     pc_in = ctrl.target;
         default:              pc_in = bq_pkg::S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bq_pkg::S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> sv/bq_datapath.sv
module bq_datapath #(
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bq_pkg::bq_ctrl_type          ctrl,
   input  bq_pkg::bq_coef_set_type      coefs,
   input  logic                         req_fire,
   input  logic [bq_pkg::X_W-1:0]       req_sample,
   input  logic                         req_restart,
   output logic [bq_pkg::CODE_W-1:0]    code
);

   localparam int ACC_W  = bq_pkg::ACC_W;
   localparam int Y_W    = bq_pkg::Y_W;
   localparam int N_W    = bq_pkg::N_W;
   localparam int M_W    = bq_pkg::M_W;
   localparam int P_W    = bq_pkg::P_W;
   localparam int Q_W    = bq_pkg::CODE_W;
   localparam int T_W    = P_W + 4;
   localparam int R_W    = P_W + 1;

   localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] Y_MAX_X =
      {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_MIN_X = ~Y_MAX_X;
   localparam logic signed [M_W-1:0] M_LO = M_W'(-bq_pkg::DAC_OFS);
   localparam logic signed [M_W-1:0] M_HI = M_W'(bq_pkg::DAC_OFS - 1);

   // history
   logic signed [bq_pkg::X_W-1:0] x0_ff, x1_ff, x2_ff;
   logic signed [Y_W-1:0]         y1_ff, y2_ff;

   // mac
   logic signed [bq_pkg::COEF_W-1:0]  mul_a;
   logic signed [bq_pkg::MUL_B_W-1:0] mul_b;
   logic signed [bq_pkg::PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]           term, acc_in, acc_ff, ysh;
   logic signed [Y_W-1:0]             y_sat;

   // dac scaling
   logic signed [N_W-1:0] n_val;
   logic signed [M_W-1:0] m_ff, p_sum;
   logic [P_W-1:0]        p_in, p_ff;
   logic [T_W-1:0]        t_val;
   logic [Q_W-1:0]        q0_in, q0_ff;
   logic                  clamp_lo_ff, clamp_hi_ff;
   logic [R_W-1:0]        qm, r_val;

   always_comb begin
      case (ctrl.mul_sel)
         bq_pkg::MUL_B0_X: begin
            mul_a = coefs.b0; mul_b = bq_pkg::MUL_B_W'(x0_ff);
         end
         bq_pkg::MUL_B1_X1: begin
            mul_a = coefs.b1; mul_b = bq_pkg::MUL_B_W'(x1_ff);
         end
         bq_pkg::MUL_B2_X2: begin
            mul_a = coefs.b2; mul_b = bq_pkg::MUL_B_W'(x2_ff);
         end
         bq_pkg::MUL_A1_Y1H: begin
            mul_a = coefs.a1; mul_b = {y1_ff[Y_W-1], y1_ff[Y_W-1:16]};
         end
         bq_pkg::MUL_A1_Y1L: begin
            mul_a = coefs.a1; mul_b = {9'd0, y1_ff[15:0]};
         end
         bq_pkg::MUL_A2_Y2H: begin
            mul_a = coefs.a2; mul_b = {y2_ff[Y_W-1], y2_ff[Y_W-1:16]};
         end
         bq_pkg::MUL_A2_Y2L: begin
            mul_a = coefs.a2; mul_b = {9'd0, y2_ff[15:0]};
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign term = ctrl.acc_shift ? (ACC_W'(prod_ff) <<< 16) : ACC_W'(prod_ff);

   always_comb begin
      case (ctrl.acc_op)
         bq_pkg::ACC_LOAD: acc_in = RND + term;
         bq_pkg::ACC_ADD:  acc_in = acc_ff + term;
         bq_pkg::ACC_SUB:  acc_in = acc_ff - term;
         default:          acc_in = acc_ff;
      endcase
   end

   // round half up already folded in, so a floor shift finishes it
   assign ysh = acc_ff >>> COEF_FRAC_BITS;

   always_comb begin
      if (ysh > Y_MAX_X) begin
         y_sat = Y_MAX_X[Y_W-1:0];
      end else if (ysh < Y_MIN_X) begin
         y_sat = Y_MIN_X[Y_W-1:0];
      end else begin
         y_sat = ysh[Y_W-1:0];
      end
   end

   // y*546 as shifts, plus half the divisor
   assign n_val = (N_W'(y1_ff) <<< 9) + (N_W'(y1_ff) <<< 5) + (N_W'(y1_ff) <<< 1)
                + N_W'(bq_pkg::DAC_HALF);

   assign p_sum = m_ff + M_W'(bq_pkg::DAC_OFS);
   assign p_in  = p_sum[P_W-1:0];
   // p*15/65536 lands on the quotient or one below
   assign t_val = (T_W'(p_in) << 4) - T_W'(p_in);
   assign q0_in = t_val[T_W-2:16];

   assign qm    = (R_W'(q0_ff) << 12) + (R_W'(q0_ff) << 8) + (R_W'(q0_ff) << 4)
                + R_W'(q0_ff);
   assign r_val = R_W'(p_ff) - qm;

   always_comb begin
      if (clamp_lo_ff) begin
         code = '0;
      end else if (clamp_hi_ff) begin
         code = Q_W'(bq_pkg::DAC_MAX);
      end else if (r_val >= R_W'(bq_pkg::DAC_DIV)) begin
         code = q0_ff + 1'b1;
      end else begin
         code = q0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (req_fire && req_restart) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (ctrl.dp_op == bq_pkg::DP_SAT) begin
         x2_ff <= x1_ff;
         x1_ff <= x0_ff;
         y2_ff <= y1_ff;
         y1_ff <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x0_ff <= {~req_sample[bq_pkg::X_W-1], req_sample[bq_pkg::X_W-2:0]};
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.dp_op == bq_pkg::DP_DAC_M) begin
         m_ff <= n_val[N_W-1:16];
      end
      if (ctrl.dp_op == bq_pkg::DP_DAC_Q) begin
         p_ff        <= p_in;
         q0_ff       <= q0_in;
         clamp_lo_ff <= m_ff < M_LO;
         clamp_hi_ff <= m_ff > M_HI;
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// self-checking bench for the adc-to-dac biquad: a directed table first, then
// random coefficient phases, each request predicted in step with the block
module tb;

   localparam int FRAC             = 28;     // coefficient fraction bits
   localparam int IDLE_LIMIT       = 2000;   // cycles with no handshake or bus activity
   localparam int SETTLE_CYCLES    = 20;     // more than one sample's latency
   localparam int N_PHASES         = 8;
   localparam int ITEMS_PER_PHASE  = 79;
   localparam int LONG_HOLD_AT     = 120;    // result count that starts the hold
   localparam int LONG_HOLD_CYCLES = 400;

   // addresses past the last coefficient, writes there must be dropped
   localparam logic [bq_pkg::IDX_W-1:0] REG_HOLE_LO = 3'd5;
   localparam logic [bq_pkg::IDX_W-1:0] REG_HOLE_HI = 3'd7;

   // coefficient mixes used by the random phases
   localparam int MIX_WILD    = 0;   // any 32-bit value
   localparam int MIX_STABLE  = 1;   // gentle feedback
   localparam int MIX_FIR     = 2;   // feedback off
   localparam int MIX_CORNERS = 3;   // extremes and unity

   localparam logic signed [95:0] Y_TOP      = (96'sd1 <<< 39) - 96'sd1;
   localparam logic signed [95:0] Y_BOTTOM   = -(96'sd1 <<< 39);
   localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (FRAC - 1);
   localparam logic signed [95:0] DAC_DEN    = 96'sd4294901760;   // 65535 * 65536

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] adc_sample
   logic        req_tuser  = 1'b0; // [0] restart

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [11:0] dac_code, [15:12] zero

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [bq_pkg::ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]               csr_pwdata  = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // rides along with each request: a code read straight off the table
   logic        req_typed      = 1'b0;
   logic [11:0] req_typed_code = '0;

   // random idling, each side flips between gappy and back-to-back
   logic req_quiet = 1'b0;
   logic rsp_quiet = 1'b0;

   int err_cnt = 0;

   // dac codes owed by the block, oldest first
   logic [11:0] dac_code_due_q[$];

   // filter image: coefficients and the two histories
   logic signed [31:0] coef_now [5];
   logic signed [15:0] x_d1, x_d2;
   logic signed [39:0] y_d1, y_d2;

   always #5 clock = ~clock;

   biquad_adc_to_dac_filter #(
      .COEF_FRAC_BITS(FRAC)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // one sample through the filter image, returns the dac code and shifts
   // the histories
   function automatic logic [11:0] filter_sample(input logic [15:0] adc,
                                                 input logic restart);
      logic signed [16:0] x;
      logic signed [95:0] acc;
      logic signed [95:0] y;
      logic signed [95:0] num;
      logic signed [95:0] q;
      if (restart) begin
         x_d1 = '0;
         x_d2 = '0;
         y_d1 = '0;
         y_d2 = '0;
      end
      // remove mid scale
      x = $signed({1'b0, adc}) - 17'sd32768;
      // exact sum in units of 2^-(frac+16), plus half an output lsb
      acc = (coef_now[bq_pkg::REG_B0] * x + coef_now[bq_pkg::REG_B1] * x_d1
             + coef_now[bq_pkg::REG_B2] * x_d2) * 96'sd65536
            - coef_now[bq_pkg::REG_A1] * y_d1 - coef_now[bq_pkg::REG_A2] * y_d2
            + ROUND_HALF;
      // floor shift gives round half up to q24.16
      y = acc >>> FRAC;
      if (y > Y_TOP)
         y = Y_TOP;
      else if (y < Y_BOTTOM)
         y = Y_BOTTOM;
      x_d2 = x_d1;
      x_d1 = x[15:0];
      y_d2 = y_d1;
      y_d1 = y[39:0];
      // 2048 + y * 8190/65535, half up, clamped
      num = y * 96'sd8190 + 96'sd2048 * DAC_DEN + DAC_DEN / 96'sd2;
      if (num < 0)
         return '0;
      q = num / DAC_DEN;
      if (q > bq_pkg::DAC_MAX)
         return 12'(bq_pkg::DAC_MAX);
      return q[11:0];
   endfunction

   // watch every edge: track coefficient writes, predict each accepted request
   // and match each accepted result against the oldest prediction
   logic [11:0] predicted_code;
   logic [11:0] due_code;

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) coef_now[k] = '0;
         x_d1 = '0;
         x_d2 = '0;
         y_d1 = '0;
         y_d2 = '0;
      end else begin
         // only the five coefficient slots exist, anything above is dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[4:2] <= bq_pkg::REG_A2)
            coef_now[csr_paddr[4:2]] = csr_pwdata;

         if (req_tvalid && req_tready) begin
            predicted_code = filter_sample(req_tdata, req_tuser);
            // a table row with a typed code overrides the image
            dac_code_due_q.push_back(req_typed ? req_typed_code : predicted_code);
         end

         if (rsp_tvalid && rsp_tready) begin
            if (dac_code_due_q.size() == 0) begin
               $error("rsp: result with no request outstanding, dac_code %0d",
                      rsp_tdata[11:0]);
               err_cnt++;
            end else begin
               due_code = dac_code_due_q.pop_front();
               if (rsp_tdata[11:0] !== due_code) begin
                  $error("dac_code: expected %0d, got %0d", due_code, rsp_tdata[11:0]);
                  err_cnt++;
               end
               if (rsp_tdata[15:12] !== 4'd0) begin
                  $error("rsp_tdata pad: expected 0, got %0h", rsp_tdata[15:12]);
                  err_cnt++;
               end
            end
         end
      end
   end

   // present one request and hold it until the block takes it
   task automatic offer_sample(input logic [15:0] adc, input logic restart,
                               input logic typed, input logic [11:0] code);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 31) == 0) req_quiet = !req_quiet;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid     <= 1'b1;
      req_tdata      <= adc;
      req_tuser      <= restart;
      req_typed      <= typed;
      req_typed_code <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering, let every owed result come out, then give the block a
   // few spare cycles so it is back at rest
   task automatic drain_and_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dac_code_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup, access, then a dead cycle so psel never toggles twice
   // in one step
   task automatic write_coef(input logic [bq_pkg::IDX_W-1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // random coefficient for one phase, feedback taps kept tamer when asked
   function automatic logic [31:0] pick_coef(input int mix, input logic feedback);
      int v;
      case (mix)
         MIX_WILD: v = int'($urandom);
         MIX_STABLE: begin
            if (feedback)
               v = int'($urandom_range(0, 1 << 28)) - (1 << 27);
            else
               v = int'($urandom_range(0, 1 << 30)) - (1 << 29);
         end
         MIX_FIR: v = feedback ? 0 : int'($urandom);
         MIX_CORNERS: begin
            case ($urandom_range(0, 6))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 0;
               3: v = 1;
               4: v = -1;
               5: v = 1 << FRAC;
               default: v = -(1 << FRAC);
            endcase
         end
         default: v = int'($urandom);
      endcase
      return v;
   endfunction

   // random adc code, leaning on the rails and the mid code now and then
   function automatic logic [15:0] pick_adc();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'(32768 + int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // directed table: one row is either a coefficient write or a request
   typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [bq_pkg::IDX_W-1:0] reg_idx;
      logic [31:0]              reg_val;
      logic [15:0]              adc;
      logic                     restart;
      logic                     typed;
      logic [11:0]              code;
   } plan_row_type;

   plan_row_type plan[$];

   function automatic void add_coef(input logic [bq_pkg::IDX_W-1:0] idx,
                                    input logic [31:0] val);
      plan.push_back('{ROW_COEF, idx, val, '0, 1'b0, 1'b0, '0});
   endfunction

   function automatic void add_sample(input logic [15:0] adc, input logic restart);
      plan.push_back('{ROW_SAMPLE, '0, '0, adc, restart, 1'b0, '0});
   endfunction

   function automatic void add_checked(input logic [15:0] adc, input logic restart,
                                       input logic [11:0] code);
      plan.push_back('{ROW_SAMPLE, '0, '0, adc, restart, 1'b1, code});
   endfunction

   // result side: random stalls, back-to-back stretches, and one long hold-off
   // while the sender keeps pushing so the block backs up into its input
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == LONG_HOLD_AT)
            gap = LONG_HOLD_CYCLES;
         else
            gap = rsp_quiet ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 31) == 0) rsp_quiet = !rsp_quiet;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   // watchdog: any handshake or bus activity resets the count
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // main sequence
   initial begin
      logic in_csr;
      int   mix;

      // coefficients come out of reset at zero, so every sample lands on mid code
      add_checked(16'h0000, 1'b0, 12'd2048);
      add_checked(16'hffff, 1'b1, 12'd2048);
      add_checked(16'h8000, 1'b0, 12'd2048);

      // unity pass-through: the rails clamp to both ends of the dac
      add_coef(bq_pkg::REG_B0, 32'h1000_0000);
      add_checked(16'h0000, 1'b0, 12'd0);
      add_checked(16'hffff, 1'b0, 12'd4095);
      add_checked(16'h8000, 1'b1, 12'd2048);

      // every tap at an extreme: history saturates both ways, restart clears it
      add_coef(bq_pkg::REG_B0, 32'h7fff_ffff);
      add_coef(bq_pkg::REG_B1, 32'h8000_0000);
      add_coef(bq_pkg::REG_B2, 32'h7fff_ffff);
      add_coef(bq_pkg::REG_A1, 32'h8000_0000);
      add_coef(bq_pkg::REG_A2, 32'h7fff_ffff);
      add_sample(16'hffff, 1'b1);
      add_sample(16'hffff, 1'b0);
      add_sample(16'hffff, 1'b0);
      add_sample(16'hffff, 1'b0);
      add_sample(16'h0000, 1'b0);
      add_sample(16'h0000, 1'b0);
      add_sample(16'h0000, 1'b0);
      add_sample(16'h8000, 1'b1);
      add_sample(16'h3039, 1'b0);

      // one-lsb gain puts the sum exactly on a half, which must round up;
      // writes above the last coefficient must leave all taps alone
      add_coef(bq_pkg::REG_B0, 32'h0000_0001);
      add_coef(bq_pkg::REG_B1, 32'h0000_0000);
      add_coef(bq_pkg::REG_B2, 32'h0000_0000);
      add_coef(bq_pkg::REG_A1, 32'h0000_0000);
      add_coef(bq_pkg::REG_A2, 32'h0000_0000);
      add_coef(REG_HOLE_LO, 32'hffff_ffff);
      add_coef(REG_HOLE_HI, 32'h8000_0000);
      add_sample(16'h8800, 1'b1);
      add_sample(16'h7800, 1'b0);
      add_sample(16'h8800, 1'b0);

      // synchronous reset, held high from time zero
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_csr = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_COEF) begin
            // registers only change with the pipe empty
            if (!in_csr) drain_and_idle();
            in_csr = 1'b1;
            write_coef(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            in_csr = 1'b0;
            offer_sample(plan[i].adc, plan[i].restart, plan[i].typed, plan[i].code);
         end
      end

      // random phases, each with a fresh coefficient set
      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain_and_idle();
         mix = phase % 4;
         write_coef(bq_pkg::REG_B0, pick_coef(mix, 1'b0));
         write_coef(bq_pkg::REG_B1, pick_coef(mix, 1'b0));
         write_coef(bq_pkg::REG_B2, pick_coef(mix, 1'b0));
         write_coef(bq_pkg::REG_A1, pick_coef(mix, 1'b1));
         write_coef(bq_pkg::REG_A2, pick_coef(mix, 1'b1));
         write_coef($urandom_range(0, 1) ? REG_HOLE_LO : REG_HOLE_HI, $urandom);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_sample(pick_adc(), $urandom_range(0, 15) == 0, 1'b0, '0);
      end

      drain_and_idle();
      if (err_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
